[hw/rtl/packed_trie_keyword_matcher_defines.svh]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher: assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// -----------------------------------------------------------------------------
`ifndef PACKED_TRIE_KEYWORD_MATCHER_DEFINES_SVH
`define PACKED_TRIE_KEYWORD_MATCHER_DEFINES_SVH

// Checked outside reset only.
`define PTKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTKM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/ptkm_pkg.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher package
// Table geometry, entry encoding, and controller/datapath command and status.
// -----------------------------------------------------------------------------
`default_nettype none

package ptkm_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  // walk position may run past the end of the table by up to one offset byte's value
  localparam int unsigned PosW       = $clog2(TableDepth + 256);
  localparam int unsigned StepW      = $clog2(TableDepth + 2);

  localparam int unsigned TblAddrW   = 10;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 7;

  localparam logic [ByteW-1:0] ForkBit  = 8'h80;
  localparam logic [ByteW-1:0] CharMask = 8'h7F;
  localparam logic [ByteW-1:0] EndChar  = 8'h00;

  localparam logic OpWrite = 1'b0;
  localparam logic OpChar  = 1'b1;

  typedef struct packed {
    logic table_wr;
    logic latch;
    logic rd_entry;
    logic rd_offset;
    logic adv_fork;
    logic adv_plain;
    logic skip;
    logic save_pos;
    logic set_fault;
    logic set_failed;
    logic park;
    logic emit_hit;
    logic emit_miss;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic in_char_zero;
    logic blocked;
    logic char_zero;
    logic pos_oob;
    logic pos1_oob;
    logic steps_over;
    logic is_fork;
    logic fork_hit;
    logic plain_hit;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/ptkm_if.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher channels
// Valid/ready channels for input items and result items.
// -----------------------------------------------------------------------------
`default_nettype none

interface ptkm_in_if;
  import ptkm_pkg::*;

  logic                valid;
  logic                ready;
  logic                op;
  logic [TblAddrW-1:0] table_address;
  logic [ByteW-1:0]    table_byte;
  logic [ByteW-1:0]    character;

  modport source (output valid, op, table_address, table_byte, character, input ready);
  modport sink   (input valid, op, table_address, table_byte, character, output ready);
  modport monitor (input valid, ready, op, table_address, table_byte, character);
endinterface

interface ptkm_out_if;
  import ptkm_pkg::*;

  logic             valid;
  logic             ready;
  logic             matched;
  logic [CodeW-1:0] keyword_code;
  logic             fault;

  modport source (output valid, matched, keyword_code, fault, input ready);
  modport sink   (input valid, matched, keyword_code, fault, output ready);
  modport monitor (input valid, ready, matched, keyword_code, fault);
endinterface

`default_nettype wire

[hw/rtl/ptkm_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module ptkm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/ptkm_ctrl.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher controller
// Sequences table writes and the per-character trie walk.
// -----------------------------------------------------------------------------
`default_nettype none

module ptkm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire ptkm_pkg::status_t status_i,
  output      ptkm_pkg::cmd_t    cmd_o
);
  import ptkm_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StRead    = 3'd1;
  localparam logic [2:0] StEval    = 3'd2;
  localparam logic [2:0] StSkip    = 3'd3;
  localparam logic [2:0] StCodeRd  = 3'd4;
  localparam logic [2:0] StEmitHit = 3'd5;
  localparam logic [2:0] StFinish  = 3'd6;
  localparam logic [2:0] StEmitMis = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (status_i.op == OpWrite) begin
            cmd_o.table_wr = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            if (!status_i.blocked) begin
              state_d = StRead;
            end else if (status_i.in_char_zero) begin
              state_d = StEmitMis;
            end
          end
        end
      end
      StRead: begin
        if (status_i.pos_oob || status_i.steps_over) begin
          cmd_o.set_fault = 1'b1;
          state_d = StFinish;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d = StEval;
        end
      end
      StEval: begin
        if (status_i.is_fork && !status_i.fork_hit) begin
          if (status_i.pos1_oob) begin
            cmd_o.set_fault = 1'b1;
            state_d = StFinish;
          end else begin
            cmd_o.rd_offset = 1'b1;
            state_d = StSkip;
          end
        end else if (status_i.is_fork || status_i.plain_hit) begin
          cmd_o.adv_fork  = status_i.is_fork;
          cmd_o.adv_plain = !status_i.is_fork;
          if (status_i.char_zero) begin
            state_d = StCodeRd;
          end else begin
            cmd_o.save_pos = 1'b1;
            state_d = StIdle;
          end
        end else begin
          cmd_o.set_failed = 1'b1;
          state_d = StFinish;
        end
      end
      StSkip: begin
        cmd_o.skip = 1'b1;
        state_d = StRead;
      end
      StCodeRd: begin
        if (status_i.pos_oob) begin
          cmd_o.set_fault = 1'b1;
          state_d = StFinish;
        end else begin
          cmd_o.rd_entry = 1'b1;
          state_d = StEmitHit;
        end
      end
      StEmitHit: begin
        if (!status_i.out_busy) begin
          cmd_o.emit_hit = 1'b1;
          state_d = StIdle;
        end
      end
      StFinish: begin
        if (status_i.char_zero) begin
          state_d = StEmitMis;
        end else begin
          cmd_o.park = 1'b1;
          state_d = StIdle;
        end
      end
      StEmitMis: begin
        if (!status_i.out_busy) begin
          cmd_o.emit_miss = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ptkm_dp.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher datapath
// Trie table, walk position, step count, token flags and result register.
// -----------------------------------------------------------------------------
`default_nettype none

module ptkm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_op_i,
  input  wire logic [ptkm_pkg::TblAddrW-1:0] in_table_address_i,
  input  wire logic [ptkm_pkg::ByteW-1:0]    in_table_byte_i,
  input  wire logic [ptkm_pkg::ByteW-1:0]    in_character_i,
  input  wire ptkm_pkg::cmd_t                cmd_i,
  output      ptkm_pkg::status_t             status_o,
  ptkm_out_if.source                         out_o
);
  import ptkm_pkg::*;

  logic [ByteW-1:0] char_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  walk_pos_q;
  logic [StepW-1:0] steps_q;
  logic             failed_q;
  logic             fault_q;
  logic             out_valid_q;
  logic             out_matched_q;
  logic [CodeW-1:0] out_code_q;
  logic             out_fault_q;

  logic [ByteW-1:0] entry;
  logic [PosW-1:0]  pos_inc;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             emit;

  assign wr_en   = cmd_i.table_wr && (32'(in_table_address_i) < TableDepth);
  assign pos_inc = pos_q + PosW'(1);
  assign rd_en   = cmd_i.rd_entry || cmd_i.rd_offset;
  assign rd_addr = cmd_i.rd_offset ? pos_inc[AddrW-1:0] : pos_q[AddrW-1:0];

  ptkm_ram #(
    .Width (ByteW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(in_table_address_i)),
    .wdata_i (in_table_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (entry)
  );

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.latch) begin
      pos_d = walk_pos_q;
    end else if (cmd_i.adv_fork) begin
      pos_d = pos_q + PosW'(2);
    end else if (cmd_i.adv_plain) begin
      pos_d = pos_inc;
    end else if (cmd_i.skip) begin
      pos_d = pos_q + PosW'(entry);
    end
  end

  assign emit = cmd_i.emit_hit || cmd_i.emit_miss;

  assign status_o.op           = in_op_i;
  assign status_o.in_char_zero = (in_character_i == EndChar);
  assign status_o.blocked      = failed_q || fault_q;
  assign status_o.char_zero    = (char_q == EndChar);
  assign status_o.pos_oob      = (32'(pos_q) >= TableDepth);
  assign status_o.pos1_oob     = (32'(pos_inc) >= TableDepth);
  assign status_o.steps_over   = (32'(steps_q) > TableDepth);
  assign status_o.is_fork      = ((entry & ForkBit) != '0);
  assign status_o.fork_hit     = (char_q == (entry & CharMask));
  assign status_o.plain_hit    = (char_q == entry);
  assign status_o.out_busy     = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      char_q <= in_character_i;
    end
    pos_q <= pos_d;
    if (cmd_i.latch) begin
      steps_q <= '0;
    end else if (cmd_i.skip) begin
      steps_q <= steps_q + StepW'(1);
    end
    if (cmd_i.emit_hit) begin
      out_matched_q <= 1'b1;
      out_code_q    <= CodeW'(entry & CharMask);
      out_fault_q   <= 1'b0;
    end else if (cmd_i.emit_miss) begin
      out_matched_q <= 1'b0;
      out_code_q    <= '0;
      out_fault_q   <= fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_pos_q  <= '0;
      failed_q    <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit || cmd_i.park) begin
        walk_pos_q <= '0;
      end else if (cmd_i.save_pos) begin
        walk_pos_q <= pos_d;
      end
      if (emit) begin
        failed_q <= 1'b0;
        fault_q  <= 1'b0;
      end else begin
        if (cmd_i.set_failed) begin
          failed_q <= 1'b1;
        end
        if (cmd_i.set_fault) begin
          fault_q <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.matched      = out_matched_q;
  assign out_o.keyword_code = out_code_q;
  assign out_o.fault        = out_fault_q;

endmodule

`default_nettype wire

[hw/rtl/packed_trie_keyword_matcher.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher
// Walks a byte-packed keyword trie one token character at a time.
// -----------------------------------------------------------------------------
// Input transfers either write one trie table byte or present one token
// character. A character walks the table through a single read port with
// registered data: the entry at the walk position is read and evaluated, and
// each fork entry skipped on a mismatch adds an offset read and a skip. A
// matching terminator reads its keyword code before its result transfer is
// loaded; one that runs off the table end yields a fault result. After a
// failed or faulted walk, characters start no walk and their terminator loads
// a miss result. The table has no reset; the result register holds one
// pending result while the next input transfer is taken, and a new result
// waits, with the input held off, until the pending one is accepted.
`default_nettype none

module packed_trie_keyword_matcher (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  ptkm_in_if.sink    in_i,
  ptkm_out_if.source out_o
);
  import ptkm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  ptkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptkm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_op_i            (in_i.op),
    .in_table_address_i (in_i.table_address),
    .in_table_byte_i    (in_i.table_byte),
    .in_character_i     (in_i.character),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_o              (out_o)
  );

endmodule

`default_nettype wire

[hw/rtl/ptkm_checker.sv]
// -----------------------------------------------------------------------------
// Packed trie keyword matcher checker
// Port-level properties of the result channel, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "packed_trie_keyword_matcher_defines.svh"

module ptkm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       out_matched_i,
  input wire logic [ptkm_pkg::CodeW-1:0] out_keyword_code_i,
  input wire logic                       out_fault_i
);

  `PTKM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result valid in reset")
  `PTKM_ASSERT(a_miss_code_zero, out_valid_i && !out_matched_i |-> out_keyword_code_i == '0, "code set on a miss")
  `PTKM_ASSERT(a_hit_not_fault, out_valid_i |-> !(out_matched_i && out_fault_i), "match with fault")
  `PTKM_ASSERT(a_result_held, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_matched_i) && $stable(out_keyword_code_i) && $stable(out_fault_i), "stalled result changed")

endmodule

bind packed_trie_keyword_matcher ptkm_checker u_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_matched_i      (out_o.matched),
  .out_keyword_code_i (out_o.keyword_code),
  .out_fault_i        (out_o.fault)
);

`default_nettype wire
